FILE: design/extended_gcd_assert.svh
// Assertion macros shared by the extended GCD modules.
`ifndef EXTENDED_GCD_ASSERT_SVH
`define EXTENDED_GCD_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define EGCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define EGCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/egcd_pkg.sv
// Shared types and constants for the extended GCD block.
package egcd_pkg;

  // Result field widths
  localparam int COEF_WIDTH = 32;
  localparam int GCD_WIDTH  = 31;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new request into the working registers
    logic div_start;  // load the divider with r_prev / r_cur
    logic div_step;   // one quotient bit
    logic mul;        // form q*s_cur and q*t_cur
    logic upd;        // advance the remainder and coefficient sequences
    logic emit;       // copy the finished result into the output registers
  } egcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rcur_zero;  // current remainder is zero: loop done
    logic div_last;   // divider takes its final bit this cycle
  } egcd_sts_t;

endpackage

FILE: design/extended_gcd.sv
// Extended GCD: runs the Euclid steps for one request, from accept to out_valid.
// Each step: zero test, bit-serial divide, multiply, update.
// At most about 46 Euclid steps for 31-bit operands; one request is worked on at a time.
// Synchronous active-low reset clears the controller and the output valid.
module extended_gcd #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [OPERAND_WIDTH-1:0]               in_first_operand,
  input  logic [OPERAND_WIDTH-1:0]               in_second_operand,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] out_coef_first,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] out_coef_second,
  output logic [egcd_pkg::GCD_WIDTH-1:0]         out_gcd_value
);
  import egcd_pkg::*;

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  egcd_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .op_a   (in_first_operand),
    .op_b   (in_second_operand),
    .coef_x (out_coef_first),
    .coef_y (out_coef_second),
    .gcd    (out_gcd_value)
  );

endmodule

FILE: design/egcd_div.sv
// Restoring divider, one quotient bit per cycle while step is held.
module egcd_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         step,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem,
  output logic         last
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, divisor};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
    end else if (step && (cnt_r != '0)) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign last = (cnt_r == CW'(1));

endmodule

FILE: design/egcd_dp.sv
// Datapath: remainder and Bezout coefficient registers, divider, multipliers.
module egcd_dp #(
  parameter int W = 31
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  egcd_pkg::egcd_cmd_t                  cmd,
  output egcd_pkg::egcd_sts_t                  sts,
  input  logic [W-1:0]                         op_a,
  input  logic [W-1:0]                         op_b,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_x,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_y,
  output logic [egcd_pkg::GCD_WIDTH-1:0]       gcd
);
  import egcd_pkg::*;

  // Remainder sequence
  logic [W-1:0] r_prev_r, r_cur_r;
  // Coefficients are only needed modulo 2^32
  logic [COEF_WIDTH-1:0] s_prev_r, s_cur_r, t_prev_r, t_cur_r;
  logic [COEF_WIDTH-1:0] prod_s_r, prod_t_r;
  logic [COEF_WIDTH-1:0] q32;
  logic [W-1:0] quo, rem;
  logic         div_last;
  logic signed [COEF_WIDTH-1:0] out_x_r, out_y_r;
  logic [GCD_WIDTH-1:0]         out_g_r;

  egcd_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (r_prev_r),
    .divisor  (r_cur_r),
    .quo      (quo),
    .rem      (rem),
    .last     (div_last)
  );

  assign q32 = COEF_WIDTH'(quo);

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_prev_r <= op_a;
      r_cur_r  <= op_b;
      s_prev_r <= COEF_WIDTH'(1);
      s_cur_r  <= '0;
      t_prev_r <= '0;
      t_cur_r  <= COEF_WIDTH'(1);
    end else if (cmd.upd) begin
      r_prev_r <= r_cur_r;
      r_cur_r  <= rem;
      s_prev_r <= s_cur_r;
      s_cur_r  <= s_prev_r - prod_s_r;
      t_prev_r <= t_cur_r;
      t_cur_r  <= t_prev_r - prod_t_r;
    end
  end

  // Quotient times coefficient, registered before the subtract
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_s_r <= q32 * s_cur_r;
      prod_t_r <= q32 * t_cur_r;
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r <= s_prev_r;
      out_y_r <= t_prev_r;
      out_g_r <= GCD_WIDTH'(r_prev_r);
    end
  end

  assign coef_x = out_x_r;
  assign coef_y = out_y_r;
  assign gcd    = out_g_r;

  assign sts.rcur_zero = (r_cur_r == '0);
  assign sts.div_last  = div_last;

  `include "extended_gcd_assert.svh"

  `EGCD_ASSERT_IMP(a_rem_below_divisor, cmd.upd, rem < r_cur_r, "remainder not below divisor")
  `EGCD_ASSERT_IMP(a_no_div_by_zero, cmd.div_start, r_cur_r != '0, "division by zero started")

endmodule

FILE: design/egcd_ctrl.sv
// Controller: sequences the Euclid steps and the request handshakes.
module egcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  egcd_pkg::egcd_sts_t sts,
  output egcd_pkg::egcd_cmd_t cmd
);
  import egcd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.rcur_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on emit, cleared when the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `include "extended_gcd_assert.svh"

  `EGCD_ASSERT_IMP(a_emit_slot_free, cmd.emit, slot_free, "result overwrote a pending result")
  `EGCD_ASSERT_NXT(a_accept_to_check, in_valid && !in_stall, state_r == S_CHECK, "request not started")
  `EGCD_ASSERT_NXT(a_div_to_mul, state_r == S_DIV && sts.div_last, state_r == S_MUL, "divide did not end")

endmodule

FILE: tb/extended_gcd_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for extended_gcd: directed table, then random requests vs. a predictor.
module extended_gcd_tb;
  import egcd_pkg::*;

  localparam int OPW = 31;
  localparam logic [OPW-1:0] MAX_OPND = '1;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1700;
  localparam int PHASE_REQUESTS = 140;
  localparam int NUM_DIRECTED = 19;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_first;
    logic signed [COEF_WIDTH-1:0] coef_second;
    logic [GCD_WIDTH-1:0]         gcd_value;
  } bezout_t;

  typedef struct packed {
    bit             known;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    bezout_t        res;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [OPW-1:0]               in_first_operand;
  logic [OPW-1:0]               in_second_operand;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [COEF_WIDTH-1:0] out_coef_first;
  logic signed [COEF_WIDTH-1:0] out_coef_second;
  logic [GCD_WIDTH-1:0]         out_gcd_value;

  bezout_t pending_results[$];
  int      mismatch_count = 0;
  int      sender_idle_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles = 0;

  // Directed requests; known rows carry the obvious answer, the rest use the predictor
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b1, 31'd0, 31'd0, '{32'sd1, 32'sd0, 31'd0}},
    '{1'b1, 31'd1, 31'd0, '{32'sd1, 32'sd0, 31'd1}},
    '{1'b1, MAX_OPND, 31'd0, '{32'sd1, 32'sd0, MAX_OPND}},
    '{1'b1, 31'd0, 31'd1, '{32'sd0, 32'sd1, 31'd1}},
    '{1'b1, 31'd0, MAX_OPND, '{32'sd0, 32'sd1, MAX_OPND}},
    '{1'b1, 31'd1, 31'd1, '{32'sd0, 32'sd1, 31'd1}},
    '{1'b1, MAX_OPND, MAX_OPND, '{32'sd0, 32'sd1, MAX_OPND}},
    '{1'b1, MAX_OPND, 31'd1, '{32'sd0, 32'sd1, 31'd1}},
    '{1'b1, 31'd2147483646, 31'd1073741823, '{32'sd0, 32'sd1, 31'd1073741823}},
    '{1'b0, 31'd1, MAX_OPND, '0},
    '{1'b0, MAX_OPND, 31'd2147483646, '0},
    '{1'b0, 31'd1836311903, 31'd1134903170, '0},
    '{1'b0, 31'd1134903170, 31'd1836311903, '0},
    '{1'b0, 31'd240, 31'd46, '0},
    '{1'b0, 31'd17, 31'd3120, '0},
    '{1'b0, 31'h5555_5555, 31'h2AAA_AAAA, '0},
    '{1'b0, 31'h4000_0000, 31'h6000_0000, '0},
    '{1'b0, 31'd12, 31'd18, '0},
    '{1'b0, 31'd3, 31'd7, '0}
  };

  extended_gcd #(
    .OPERAND_WIDTH(OPW)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_operand (in_first_operand),
    .in_second_operand(in_second_operand),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coef_first   (out_coef_first),
    .out_coef_second  (out_coef_second),
    .out_gcd_value    (out_gcd_value)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Iterative Euclid with Bezout coefficients carried as 64-bit two's complement
  function automatic bezout_t solve_bezout(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
    bit [63:0] r_prev, r_cur, r_next;
    bit [63:0] s_prev, s_cur, s_next;
    bit [63:0] t_prev, t_cur, t_next;
    bit [63:0] quot;
    bezout_t   res;
    r_prev = 64'(a);
    r_cur  = 64'(b);
    s_prev = 64'd1;
    s_cur  = 64'd0;
    t_prev = 64'd0;
    t_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quot   = r_prev / r_cur;
      r_next = r_prev - quot * r_cur;
      s_next = s_prev - quot * s_cur;
      t_next = t_prev - quot * t_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      s_prev = s_cur;
      s_cur  = s_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    res.coef_first  = s_prev[COEF_WIDTH-1:0];
    res.coef_second = t_prev[COEF_WIDTH-1:0];
    res.gcd_value   = r_prev[GCD_WIDTH-1:0];
    return res;
  endfunction

  function automatic longint unsigned fib(input int k);
    longint unsigned f0, f1, nxt;
    f0 = 0;
    f1 = 1;
    for (int i = 0; i < k; i++) begin
      nxt = f0 + f1;
      f0  = f1;
      f1  = nxt;
    end
    return f0;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
  endtask

  // Drive one request; valid stays up until the block takes it
  task automatic send_request(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                              input bit known, input bezout_t typed);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_first_operand  = a;
    in_second_operand = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(known ? typed : solve_bezout(a, b));
  endtask

  // Hold off new requests until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One random request, weighted toward the interesting operand shapes
  task automatic random_request();
    logic [OPW-1:0] a, b;
    int unsigned    g, k;
    case ($urandom_range(9))
      0, 1, 2: begin
        a = OPW'($urandom);
        b = OPW'($urandom);
      end
      3: begin
        a = OPW'($urandom_range(255));
        b = OPW'($urandom_range(255));
      end
      4: begin
        a = OPW'($urandom);
        b = OPW'($urandom_range(1, 15));
      end
      5: begin
        a = OPW'($urandom);
        b = '0;
      end
      6: begin
        a = OPW'($urandom);
        b = a;
      end
      7: begin
        // shared factor so the gcd is usually large
        g = $urandom_range(1, 65535);
        a = OPW'(g * $urandom_range(32767));
        b = OPW'(g * $urandom_range(32767));
      end
      8: begin
        // consecutive Fibonacci numbers: longest step chains
        k = $urandom_range(1, 45);
        a = OPW'(fib(k + 1));
        b = OPW'(fib(k));
      end
      default: begin
        a = OPW'($urandom >> $urandom_range(31));
        b = OPW'(1) << $urandom_range(OPW - 1);
      end
    endcase
    if ($urandom_range(1) == 1) {a, b} = {b, a};
    send_request(a, b, 1'b0, '0);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Result checker: compare each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    bezout_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request pending", 64'(out_gcd_value), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_coef_first !== want.coef_first)
          flag_mismatch("coef_first", 64'(out_coef_first), 64'(want.coef_first));
        if (out_coef_second !== want.coef_second)
          flag_mismatch("coef_second", 64'(out_coef_second), 64'(want.coef_second));
        if (out_gcd_value !== want.gcd_value)
          flag_mismatch("gcd_value", 64'(out_gcd_value), 64'(want.gcd_value));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_first_operand  = '0;
    in_second_operand = '0;
    out_stall         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, no idling
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].known, directed_rows[i].res);
    end
    drain_results();

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 75; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 75; end
        default: begin sender_idle_pct = 28; stall_pct = 28; end
      endcase
      repeat (PHASE_REQUESTS) random_request();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
